// File: rtl/jsu_pkg.sv
// shared types and codes for the json string unescaper
package jsu_pkg;

	localparam int unsigned RES_MAX = 4;
	localparam int unsigned RES_IW  = 2;

	localparam logic [1:0] ST_DATA = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	// all results caused by one input item
	typedef struct packed {
		logic [RES_MAX-1:0][7:0] bytes;
		logic [RES_MAX-1:0][1:0] stat;
		logic [RES_IW-1:0]       last_idx;
	} group_t;

endpackage

// File: rtl/jsu_in_if.sv
// input byte channel
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first;
	logic       line_end;

	modport source (output valid, output data_byte, output first, output line_end,
		input ready);
	modport sink (input valid, input data_byte, input first, input line_end,
		output ready);
endinterface

// File: rtl/jsu_out_if.sv
// result byte channel
interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last;

	modport source (output valid, output out_byte, output status, output last,
		input ready);
	modport sink (input valid, input out_byte, input status, input last,
		output ready);
endinterface

// File: rtl/json_string_unescape.sv
// json string literal unescaper, top level
//
// rx carries one raw byte of a quoted json string per transfer, with the
// first flag on the opening quote and line_end on the last byte of the line.
// tx carries the decoded results: data bytes (status 0), then one terminal
// result, complete (1) or error (2); last marks the final result of an item.
// each input item is registered, decoded combinationally against the parse
// state (mode, hex digit count, code point accumulator) and its zero to four
// results are pushed as one group into a queue of DEPTH groups. an output
// register walks each group one result per transfer.
// the first result of an item passes the input register, the queue and the
// output register before it is valid on tx. throughput: one item per cycle
// while every item gives at most one result and tx is ready; a \u escape
// giving k utf-8 bytes takes k transfers on tx, and rx keeps taking bytes
// until the queue is full. reset clears the parse state to idle and empties
// the queue; bytes without the first flag are dropped while idle. when tx
// stalls, the queue fills and rx.ready drops; nothing is lost.
module json_string_unescape
	import jsu_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	jsu_in_if.sink    rx,
	jsu_out_if.source tx
);

	group_t dec_grp;
	group_t head_grp;
	logic   grp_push;
	logic   grp_pop;
	logic   fifo_full;
	logic   fifo_empty;

	jsu_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.fifo_full (fifo_full),
		.grp_push  (grp_push),
		.grp       (dec_grp)
	);

	jsu_group_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (grp_push),
		.wdata  (dec_grp),
		.pop    (grp_pop),
		.rdata  (head_grp),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	jsu_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_grp),
		.fifo_empty (fifo_empty),
		.pop        (grp_pop),
		.tx         (tx)
	);

endmodule

// File: rtl/jsu_decoder.sv
// input register, parse state and combinational escape decode
module jsu_decoder
	import jsu_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	jsu_in_if.sink rx,
	input  logic   fifo_full,
	output logic   grp_push,
	output group_t grp
);

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_TEXT = 2'd1;
	localparam logic [1:0] M_ESC  = 2'd2;
	localparam logic [1:0] M_HEX  = 2'd3;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	// {ok, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        eol_s1;

	logic [1:0]  mode_q;
	logic [1:0]  hex_q;
	logic [15:0] acc_q;

	logic [1:0]  mode_d;
	logic [1:0]  hex_d;
	logic [15:0] acc_d;
	logic [15:0] acc_new;
	logic [4:0]  hv;
	logic [2:0][7:0] dbytes;
	logic [1:0]  nd;
	logic        fail;
	logic        done;
	logic        term;
	logic [2:0]  n_res;
	logic        commit;

	assign commit   = valid_s1 && !fifo_full;
	assign rx.ready = !valid_s1 || !fifo_full;

	assign hv      = hex_digit(byte_s1);
	assign acc_new = {acc_q[11:0], hv[3:0]};

	always_comb begin
		mode_d = mode_q;
		hex_d  = hex_q;
		acc_d  = acc_q;
		dbytes = '0;
		nd     = 2'd0;
		fail   = 1'b0;
		done   = 1'b0;
		if (first_s1) begin
			hex_d = 2'd0;
			acc_d = 16'd0;
			if (byte_s1 != CH_QUOTE || eol_s1) begin
				fail = 1'b1;
			end else begin
				mode_d = M_TEXT;
			end
		end else begin
			case (mode_q)
				M_TEXT: begin
					if (byte_s1 == CH_QUOTE) begin
						done   = 1'b1;
						mode_d = M_IDLE;
					end else if (byte_s1 == CH_BSLASH) begin
						mode_d = M_ESC;
						fail   = eol_s1;
					end else begin
						dbytes[0] = byte_s1;
						nd        = 2'd1;
						fail      = eol_s1;
					end
				end
				M_ESC: begin
					mode_d = M_TEXT;
					fail   = eol_s1;
					nd     = 2'd1;
					case (byte_s1)
						CH_QUOTE, CH_BSLASH, CH_SLASH: dbytes[0] = byte_s1;
						CH_B: dbytes[0] = 8'h08;
						CH_F: dbytes[0] = 8'h0c;
						CH_N: dbytes[0] = 8'h0a;
						CH_R: dbytes[0] = 8'h0d;
						CH_T: dbytes[0] = 8'h09;
						CH_U: begin
							nd     = 2'd0;
							mode_d = M_HEX;
							hex_d  = 2'd0;
							acc_d  = 16'd0;
						end
						default: begin
							nd   = 2'd0;
							fail = 1'b1;
						end
					endcase
				end
				M_HEX: begin
					if (!hv[4]) begin
						fail = 1'b1;
					end else begin
						fail = eol_s1;
						if (hex_q == 2'd3) begin
							// code point complete, encode as utf-8
							hex_d  = 2'd0;
							acc_d  = 16'd0;
							mode_d = M_TEXT;
							if (acc_new <= 16'h007f) begin
								dbytes[0] = acc_new[7:0];
								nd        = 2'd1;
							end else if (acc_new <= 16'h07ff) begin
								dbytes[0] = 8'hc0 | {3'd0, acc_new[10:6]};
								dbytes[1] = 8'h80 | {2'd0, acc_new[5:0]};
								nd        = 2'd2;
							end else begin
								dbytes[0] = 8'he0 | {4'd0, acc_new[15:12]};
								dbytes[1] = 8'h80 | {2'd0, acc_new[11:6]};
								dbytes[2] = 8'h80 | {2'd0, acc_new[5:0]};
								nd        = 2'd3;
							end
						end else begin
							hex_d = hex_q + 2'd1;
							acc_d = acc_new;
						end
					end
				end
				default: mode_d = M_IDLE;
			endcase
		end
		if (fail) begin
			mode_d = M_IDLE;
			hex_d  = 2'd0;
			acc_d  = 16'd0;
		end
	end

	assign term  = fail || done;
	assign n_res = {1'b0, nd} + {2'd0, term};

	always_comb begin
		grp = '0;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < nd) begin
				grp.bytes[i] = dbytes[i];
			end
		end
		if (term) begin
			grp.stat[nd] = fail ? ST_ERR : ST_DONE;
		end
		grp.last_idx = 2'(n_res - 3'd1);
	end

	assign grp_push = commit && (n_res != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1  <= rx.data_byte;
			first_s1 <= rx.first;
			eol_s1   <= rx.line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			hex_q  <= 2'd0;
			acc_q  <= 16'd0;
		end else if (commit) begin
			mode_q <= mode_d;
			hex_q  <= hex_d;
			acc_q  <= acc_d;
		end
	end

endmodule

// File: rtl/jsu_group_fifo.sv
// small queue of result groups
module jsu_group_fifo
	import jsu_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t wdata,
	input  logic   pop,
	output group_t rdata,
	output logic   full,
	output logic   empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	group_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/jsu_serializer.sv
// output register that hands out one result of a group per transfer
module jsu_serializer
	import jsu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  group_t    head,
	input  logic      fifo_empty,
	output logic      pop,
	jsu_out_if.source tx
);

	logic              valid_q;
	group_t            grp_q;
	logic [RES_IW-1:0] idx_q;
	logic              at_last;

	assign at_last = (idx_q == grp_q.last_idx);
	// refill when empty or when the last result of the group is leaving
	assign pop     = !fifo_empty && (!valid_q || (tx.ready && at_last));

	assign tx.valid    = valid_q;
	assign tx.out_byte = grp_q.bytes[idx_q];
	assign tx.status   = grp_q.stat[idx_q];
	assign tx.last     = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && tx.ready) begin
			if (at_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= head;
		end
	end

endmodule

// File: rtl/jsu_checker.sv
// port-level checks for the unescaper and their bind
module jsu_tx_props
	import jsu_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] tx_out_byte,
	input logic [1:0] tx_status,
	input logic       tx_last
);

	// only the three defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid |-> (tx_status == ST_DATA || tx_status == ST_DONE || tx_status == ST_ERR))
		else $error("undefined status code on tx");

	// a terminal result always closes its item
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid && tx_status != ST_DATA) |-> tx_last)
		else $error("terminal result without last");

	// terminal results carry a zero byte
	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid && tx_status != ST_DATA) |-> (tx_out_byte == 8'd0))
		else $error("terminal result with nonzero byte");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid && !tx_ready) |=> (tx_valid && $stable(tx_out_byte)
			&& $stable(tx_status) && $stable(tx_last)))
		else $error("stalled result changed");

endmodule

bind json_string_unescape jsu_tx_props u_tx_props (
	.clk         (clk),
	.arst_n      (arst_n),
	.tx_valid    (tx.valid),
	.tx_ready    (tx.ready),
	.tx_out_byte (tx.out_byte),
	.tx_status   (tx.status),
	.tx_last     (tx.last)
);

// File: dv/jsu_tb_pkg.sv
// character constants shared by the unescaper testbench files
package jsu_tb_pkg;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_U     = 8'h75;

endpackage

// File: dv/jsu_checker.sv
// checker for the json string unescaper: predicts decoded results and compares them
module jsu_checker
	import jsu_pkg::*;
	import jsu_tb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	jsu_in_if    rx,
	jsu_out_if   tx,
	output int   errors,
	output int   pending
);

	typedef enum logic [1:0] {PM_IDLE, PM_TEXT, PM_ESC, PM_HEX} parse_mode_t;

	typedef struct packed {
		logic [7:0] ob;
		logic [1:0] st;
		logic       lst;
	} decoded_t;

	decoded_t    decoded_q[$];
	parse_mode_t pmode;
	logic [1:0]  nhex;
	logic [15:0] cp;

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	// one input byte against the parse state; results go to decoded_q
	task automatic unescape_step(input logic [7:0] b, input logic f, input logic e);
		decoded_t   grp[$];
		bit         bad;
		bit         simple;
		int         d;
		logic [7:0] v;
		bad = 0;
		if (f) begin
			nhex = '0;
			cp = '0;
			if (b != CH_QUOTE || e) bad = 1;
			else pmode = PM_TEXT;
		end else begin
			case (pmode)
				PM_TEXT: begin
					if (b == CH_QUOTE) begin
						grp.insert(grp.size(), decoded_t'{8'h00, ST_DONE, 1'b0});
						pmode = PM_IDLE;
					end else if (b == CH_BSL) begin
						pmode = PM_ESC;
						bad = e;
					end else begin
						grp.insert(grp.size(), decoded_t'{b, ST_DATA, 1'b0});
						bad = e;
					end
				end
				PM_ESC: begin
					simple = 1;
					v = b;
					case (b)
						CH_QUOTE, CH_BSL, CH_SLASH: v = b;
						"b": v = 8'h08;
						"f": v = 8'h0c;
						"n": v = 8'h0a;
						"r": v = 8'h0d;
						"t": v = 8'h09;
						CH_U: simple = 0;
						default: begin
							simple = 0;
							bad = 1;
						end
					endcase
					if (simple) begin
						grp.insert(grp.size(), decoded_t'{v, ST_DATA, 1'b0});
						pmode = PM_TEXT;
						bad = e;
					end else if (!bad) begin
						pmode = PM_HEX;
						nhex = '0;
						cp = '0;
						bad = e;
					end
				end
				PM_HEX: begin
					d = nibble_of(b);
					if (d < 0) begin
						bad = 1;
					end else begin
						cp = {cp[11:0], d[3:0]};
						if (nhex == 2'd3) begin
							if (cp <= 16'h007f) begin
								grp.insert(grp.size(), decoded_t'{cp[7:0], ST_DATA, 1'b0});
							end else if (cp <= 16'h07ff) begin
								grp.insert(grp.size(),
									decoded_t'{{3'b110, cp[10:6]}, ST_DATA, 1'b0});
								grp.insert(grp.size(),
									decoded_t'{{2'b10, cp[5:0]}, ST_DATA, 1'b0});
							end else begin
								grp.insert(grp.size(),
									decoded_t'{{4'b1110, cp[15:12]}, ST_DATA, 1'b0});
								grp.insert(grp.size(),
									decoded_t'{{2'b10, cp[11:6]}, ST_DATA, 1'b0});
								grp.insert(grp.size(),
									decoded_t'{{2'b10, cp[5:0]}, ST_DATA, 1'b0});
							end
							nhex = '0;
							cp = '0;
							pmode = PM_TEXT;
						end else begin
							nhex = nhex + 2'd1;
						end
						bad = e;
					end
				end
				default: pmode = PM_IDLE;
			endcase
		end
		if (bad) begin
			grp.insert(grp.size(), decoded_t'{8'h00, ST_ERR, 1'b0});
			pmode = PM_IDLE;
			nhex = '0;
			cp = '0;
		end
		if (grp.size() > 0) grp[grp.size()-1].lst = 1'b1;
		foreach (grp[i]) decoded_q.insert(decoded_q.size(), grp[i]);
	endtask

	task automatic compare_result(input logic [7:0] ob, input logic [1:0] st, input logic lst);
		decoded_t want;
		if (decoded_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("jsu_checker: unexpected result byte %h status %0d last %b",
					ob, st, lst);
		end else begin
			want = decoded_q[0];
			decoded_q.delete(0);
			if (ob !== want.ob || st !== want.st || lst !== want.lst) begin
				errors++;
				if (errors <= 10)
					$display("jsu_checker: expected byte %h status %0d last %b, got %h %0d %b",
						want.ob, want.st, want.lst, ob, st, lst);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmode = PM_IDLE;
			nhex = '0;
			cp = '0;
			decoded_q.delete();
			pending = 0;
		end else begin
			// predict before compare so a same-edge result never races its item
			if (rx.valid && rx.ready)
				unescape_step(rx.data_byte, rx.first, rx.line_end);
			if (tx.valid && tx.ready)
				compare_result(tx.out_byte, tx.status, tx.last);
			pending = decoded_q.size();
		end
	end

endmodule

// File: dv/tb_top.sv
// testbench top for the json string unescaper: stimulus, receiver and verdict
module tb_top;
	import jsu_tb_pkg::*;

	localparam int WDOG_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int N_ITEMS     = 310;

	localparam logic [7:0] ESC_SET [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, "b", "f", "n", "r", "t"};
	localparam logic [15:0] CP_EDGES [10] = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff,
		16'h0800, 16'hd800, 16'hdbff, 16'hdc00, 16'hdfff, 16'hffff};

	logic clk;
	logic arst_n;
	bit   gaps_on;
	bit   hold_req;
	int   n_sent;
	int   n_err;
	int   n_pending;
	int   idle_run;
	int   lit_idx;

	jsu_in_if  rx();
	jsu_out_if tx();

	json_string_unescape dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.tx     (tx)
	);

	jsu_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.tx      (tx),
		.errors  (n_err),
		.pending (n_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic bit is_esc(input logic [7:0] c);
		for (int i = 0; i < 8; i++)
			if (ESC_SET[i] == c) return 1;
		return 0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit up);
		if (nib < 4'd10) return 8'("0") + 8'(nib);
		return (up ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] c;
		do c = 8'($urandom); while (is_hex(c));
		return c;
	endfunction

	function automatic logic [7:0] bad_letter();
		logic [7:0] c;
		do c = 8'($urandom); while (c == CH_U || is_esc(c));
		return c;
	endfunction

	// code points lean on the utf-8 length boundaries and the surrogate range
	function automatic logic [15:0] pick_cp();
		case ($urandom_range(4))
			0: return 16'($urandom_range(16'h007f));
			1: return 16'($urandom_range(16'h0080, 16'h07ff));
			2: return CP_EDGES[$urandom_range(9)];
			default: return 16'($urandom);
		endcase
	endfunction

	// starts and ends on a falling edge; valid stays high between back-to-back bytes
	task automatic send(input logic [7:0] b, input logic f, input logic e);
		while (gaps_on && $urandom_range(99) < 20) begin
			rx.valid <= 1'b0;
			rx.data_byte <= 8'($urandom);
			@(negedge clk);
		end
		rx.valid <= 1'b1;
		rx.data_byte <= b;
		rx.first <= f;
		rx.line_end <= e;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	// bytes without the first flag, mostly dropped while idle
	task automatic send_noise();
		int cnt;
		cnt = $urandom_range(1, 3);
		repeat (cnt) send(8'($urandom), 1'b0, 1'($urandom_range(1)));
		n_sent -= cnt;
	endtask

	task automatic send_literal(input bit broken);
		int          n_el;
		int          kind;
		int          inj;
		logic [15:0] cpt;
		logic [7:0]  b;
		inj = broken ? 20 : 0;
		if (broken && $urandom_range(9) == 0) begin
			send(8'($urandom), 1'b1, 1'($urandom_range(1)));
			return;
		end
		if (broken && $urandom_range(9) == 0) begin
			send(CH_QUOTE, 1'b1, 1'b1);
			return;
		end
		send(CH_QUOTE, 1'b1, 1'b0);
		n_el = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 5);
		repeat (n_el) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSL);
				if ($urandom_range(99) < inj) begin
					send(b, 1'b0, 1'b1);
					return;
				end
				send(b, 1'b0, 1'b0);
			end else if (kind < 70) begin
				if ($urandom_range(99) < inj) begin
					send(CH_BSL, 1'b0, 1'b1);
					return;
				end
				send(CH_BSL, 1'b0, 1'b0);
				if ($urandom_range(99) < inj) begin
					send(bad_letter(), 1'b0, 1'($urandom_range(1)));
					return;
				end
				b = ESC_SET[$urandom_range(7)];
				if ($urandom_range(99) < inj) begin
					send(b, 1'b0, 1'b1);
					return;
				end
				send(b, 1'b0, 1'b0);
			end else begin
				cpt = pick_cp();
				send(CH_BSL, 1'b0, 1'b0);
				if ($urandom_range(99) < inj) begin
					send(CH_U, 1'b0, 1'b1);
					return;
				end
				send(CH_U, 1'b0, 1'b0);
				for (int i = 3; i >= 0; i--) begin
					if ($urandom_range(99) < inj / 2) begin
						send(non_hex(), 1'b0, 1'($urandom_range(1)));
						return;
					end
					b = hex_char(cpt[4*i +: 4], 1'($urandom_range(1)));
					if ($urandom_range(99) < inj / 2) begin
						send(b, 1'b0, 1'b1);
						return;
					end
					send(b, 1'b0, 1'b0);
				end
			end
		end
		// a broken literal may be left open so the next first byte drops it
		if (broken && $urandom_range(1)) return;
		send(CH_QUOTE, 1'b0, 1'($urandom_range(1)));
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		tx.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				tx.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 0;
			end else begin
				tx.ready <= !(gaps_on && $urandom_range(99) < 20);
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	initial begin
		idle_run = 0;
		while (idle_run < WDOG_LIMIT) begin
			@(posedge clk);
			if ((rx.valid && rx.ready) || (tx.valid && tx.ready)) idle_run = 0;
			else idle_run++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.data_byte = 8'h00;
		rx.first = 1'b0;
		rx.line_end = 1'b0;
		gaps_on = 0;
		hold_req = 0;
		n_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		gaps_on = 1;

		// directed: idle drop, bad opening, extremes, 3-byte utf-8, closing on line end
		send("a", 1'b0, 1'b0);
		send("x", 1'b1, 1'b0);
		send(CH_QUOTE, 1'b1, 1'b1);
		send(CH_QUOTE, 1'b1, 1'b0);
		send(8'h00, 1'b0, 1'b0);
		send(8'hff, 1'b0, 1'b0);
		send(CH_BSL, 1'b0, 1'b0);
		send(CH_U, 1'b0, 1'b0);
		send("F", 1'b0, 1'b0);
		send("f", 1'b0, 1'b0);
		send("f", 1'b0, 1'b0);
		send("f", 1'b0, 1'b0);
		send(CH_QUOTE, 1'b0, 1'b1);
		// data on line end, escape cut by line end
		send(CH_QUOTE, 1'b1, 1'b0);
		send("q", 1'b0, 1'b1);
		send(CH_QUOTE, 1'b1, 1'b0);
		send(CH_BSL, 1'b0, 1'b1);
		// open literal dropped by a new first byte, then an unknown escape
		send(CH_QUOTE, 1'b1, 1'b0);
		send(CH_QUOTE, 1'b1, 1'b0);
		send(CH_BSL, 1'b0, 1'b0);
		send("q", 1'b0, 1'b0);
		// bad hex digit
		send(CH_QUOTE, 1'b1, 1'b0);
		send(CH_BSL, 1'b0, 1'b0);
		send(CH_U, 1'b0, 1'b0);
		send("g", 1'b0, 1'b0);

		lit_idx = 0;
		while (n_sent < N_ITEMS) begin
			gaps_on = !(lit_idx >= 8 && lit_idx < 20);
			if (lit_idx == 25) hold_req = 1;
			if ($urandom_range(99) < 6) send_noise();
			send_literal($urandom_range(99) < 20);
			lit_idx++;
		end
		rx.valid <= 1'b0;

		while (n_pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		if (n_err == 0 && n_pending == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/jsu_decoder.sv
rtl/jsu_group_fifo.sv
rtl/jsu_serializer.sv
rtl/json_string_unescape.sv
rtl/jsu_checker.sv
dv/jsu_tb_pkg.sv
dv/jsu_checker.sv
dv/tb_top.sv
